FILE: rtl/core/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// Used by tcce_ctrl, tcce_dpath and text_console_cursor_engine_unit.
package tcce_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_WIDTH     = 8;
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int ROW_W         = 5;
  localparam int COL_W         = 7;

  localparam int MOD_SHIFT = 10;
  localparam int ROW_RECIP = (1 << MOD_SHIFT) / SCREEN_HEIGHT;
  localparam int COL_RECIP = (1 << MOD_SHIFT) / SCREEN_WIDTH;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COL = 3'd4;

  localparam logic [7:0] ESCAPE_RESET  = 8'd27;
  localparam logic [7:0] CLEAR_RESET   = 8'd99;
  localparam logic [7:0] COLOR_RESET   = 8'd109;
  localparam logic [7:0] SET_ROW_RESET = 8'd121;
  localparam logic [7:0] SET_COL_RESET = 8'd120;
  localparam logic [7:0] ATTR_RESET    = 8'h0F;

  typedef struct packed {
    logic             req_type;
    logic [7:0]       byte_in;
    logic             end_of_string;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             printed;
    logic [15:0]      printed_total;
  } out_word_t;

  typedef enum logic [4:0] {
    PS_IDLE  = 5'b00001,
    PS_ESC   = 5'b00010,
    PS_COLOR = 5'b00100,
    PS_ROW   = 5'b01000,
    PS_COL   = 5'b10000
  } parse_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic read_capture;
    logic fill_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic do_clear;
    logic do_scroll;
    logic fill_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/tcce_ctrl.sv
// Sequencer for the console engine: accept, execute, fill, read and output steps.
// Depends on tcce_pkg; drives tcce_dpath through ctrl_cmd_t.
module tcce_ctrl import tcce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_EXEC = 6'b000100,
    ST_FILL = 6'b001000,
    ST_READ = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next       = state;
    cmd              = '0;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_read) begin
          state_next = ST_READ;
        end else if (stat.do_clear || stat.do_scroll) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) begin
          state_next = ST_OUT;
        end
      end
      ST_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

FILE: rtl/core/tcce_dpath.sv
// Datapath for the console engine: cell store, cursor, parser, fill sweep, output word.
// Depends on tcce_pkg; steered by tcce_ctrl through ctrl_cmd_t.
module tcce_dpath import tcce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] escape_code, clear_code, color_code, set_row_code, set_col_code;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       wd;
  logic [ADDR_W-1:0] ra;

  in_word_t          in_q;
  logic [15:0]       row_q, col_q;
  logic [ROW_W-1:0]  top_row, cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        attr;
  parse_t            parse;
  logic [15:0]       count;

  logic [ADDR_W-1:0] fill_addr, fill_last;
  logic [15:0]       fill_val;
  out_word_t         res;

  logic [7:0]        b;
  logic              print, clear, row_cmd, col_cmd, wrote, scroll;
  parse_t            parse_next;
  logic [7:0]        attr_next;
  logic [7:0]        pc_col;
  logic [5:0]        pc_row;
  logic [ROW_W-1:0]  row_next, top_next;
  logic [COL_W-1:0]  col_next;
  logic [15:0]       count_inc;
  logic [15:0]       row_rem, col_rem;
  logic [ADDR_W-1:0] cur_addr, top_base;
  logic              read_ok;

  function automatic logic [ROW_W-1:0] phys_of(input logic [ROW_W-1:0] top,
                                               input logic [ROW_W-1:0] row);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
      sum = sum - (ROW_W+1)'(SCREEN_HEIGHT);
    end
    return sum[ROW_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code  <= ESCAPE_RESET;
      clear_code   <= CLEAR_RESET;
      color_code   <= COLOR_RESET;
      set_row_code <= SET_ROW_RESET;
      set_col_code <= SET_COL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ESCAPE:  escape_code  <= cfg_data;
        CFG_CLEAR:   clear_code   <= cfg_data;
        CFG_COLOR:   color_code   <= cfg_data;
        CFG_SET_ROW: set_row_code <= cfg_data;
        CFG_SET_COL: set_col_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_q  <= in_data;
      row_q <= (16'(in_data.byte_in) * 16'(ROW_RECIP)) >> MOD_SHIFT;
      col_q <= (16'(in_data.byte_in) * 16'(COL_RECIP)) >> MOD_SHIFT;
    end
  end

  assign b = in_q.byte_in;

  always_comb begin
    print      = 1'b0;
    clear      = 1'b0;
    row_cmd    = 1'b0;
    col_cmd    = 1'b0;
    parse_next = PS_IDLE;
    attr_next  = attr;
    case (parse)
      PS_ESC: begin
        if (b == clear_code) begin
          clear = 1'b1;
        end else if (b == color_code) begin
          parse_next = PS_COLOR;
        end else if (b == set_row_code) begin
          parse_next = PS_ROW;
        end else if (b == set_col_code) begin
          parse_next = PS_COL;
        end else begin
          print = 1'b1;
        end
      end
      PS_COLOR: attr_next = b;
      PS_ROW:   row_cmd   = 1'b1;
      PS_COL:   col_cmd   = 1'b1;
      default: begin
        if (b == escape_code) begin
          parse_next = PS_ESC;
        end else begin
          print = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    row_rem = 16'(b) - row_q * 16'(SCREEN_HEIGHT);
    if (row_rem >= 16'(SCREEN_HEIGHT)) begin
      row_rem = row_rem - 16'(SCREEN_HEIGHT);
    end
    col_rem = 16'(b) - col_q * 16'(SCREEN_WIDTH);
    if (col_rem >= 16'(SCREEN_WIDTH)) begin
      col_rem = col_rem - 16'(SCREEN_WIDTH);
    end
  end

  always_comb begin
    wrote  = 1'b0;
    scroll = 1'b0;
    case (b)
      CH_CR: begin
        pc_col = '0;
        pc_row = {1'b0, cur_row};
      end
      CH_LF: begin
        pc_col = '0;
        pc_row = {1'b0, cur_row} + 6'd1;
      end
      CH_TAB: begin
        pc_col = {1'b0, cur_col} + 8'(TAB_WIDTH) - 8'(cur_col % TAB_WIDTH);
        pc_row = {1'b0, cur_row};
      end
      default: begin
        pc_col = {1'b0, cur_col} + 8'd1;
        pc_row = {1'b0, cur_row};
        wrote  = 1'b1;
      end
    endcase
    if (pc_col >= 8'(SCREEN_WIDTH)) begin
      pc_col = '0;
      pc_row = pc_row + 6'd1;
    end
    if (pc_row >= 6'(SCREEN_HEIGHT)) begin
      scroll = 1'b1;
      pc_row = 6'(SCREEN_HEIGHT - 1);
    end
  end

  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    top_next = top_row;
    if (clear) begin
      row_next = '0;
      col_next = '0;
      top_next = '0;
    end else if (row_cmd) begin
      row_next = row_rem[ROW_W-1:0];
    end else if (col_cmd) begin
      col_next = col_rem[COL_W-1:0];
    end else if (print) begin
      row_next = pc_row[ROW_W-1:0];
      col_next = pc_col[COL_W-1:0];
      if (scroll) begin
        top_next = (top_row == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : top_row + 1'b1;
      end
    end
    count_inc = count;
    if (print && count != 16'hFFFF) begin
      count_inc = count + 16'd1;
    end
  end

  assign cur_addr = ADDR_W'(phys_of(top_row, cur_row)) * ADDR_W'(SCREEN_WIDTH)
                  + ADDR_W'(cur_col);
  assign top_base = ADDR_W'(top_row) * ADDR_W'(SCREEN_WIDTH);
  assign ra       = ADDR_W'(phys_of(top_row, in_q.read_row)) * ADDR_W'(SCREEN_WIDTH)
                  + ADDR_W'(in_q.read_col);
  assign read_ok  = (in_q.read_row < ROW_W'(SCREEN_HEIGHT))
                 && (in_q.read_col < COL_W'(SCREEN_WIDTH));

  always_comb begin
    we = 1'b0;
    wa = fill_addr;
    wd = fill_val;
    if (cmd.fill_step) begin
      we = 1'b1;
    end else if (cmd.exec && !in_q.req_type && print && wrote) begin
      we = 1'b1;
      wa = cur_addr;
      wd = {attr, b};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_row   <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      attr      <= ATTR_RESET;
      parse     <= PS_IDLE;
      count     <= '0;
      fill_addr <= '0;
      fill_last <= ADDR_W'(CELLS - 1);
      fill_val  <= {ATTR_RESET, 8'h00};
    end else begin
      if (cmd.exec && !in_q.req_type) begin
        top_row <= top_next;
        cur_row <= row_next;
        cur_col <= col_next;
        attr    <= attr_next;
        parse   <= in_q.end_of_string ? PS_IDLE : parse_next;
        count   <= in_q.end_of_string ? 16'd0 : count_inc;
        if (clear) begin
          fill_addr <= '0;
          fill_last <= ADDR_W'(CELLS - 1);
          fill_val  <= {attr, 8'h00};
        end else if (print && scroll) begin
          fill_addr <= top_base;
          fill_last <= top_base + ADDR_W'(SCREEN_WIDTH - 1);
          fill_val  <= {attr, 8'h00};
        end
      end
      if (cmd.fill_step && !stat.fill_done) begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res.cell_char     <= (!in_q.req_type && print && wrote) ? b : 8'h00;
      res.cell_attr     <= (!in_q.req_type && print && wrote) ? attr : 8'h00;
      res.cursor_row    <= in_q.req_type ? cur_row : row_next;
      res.cursor_col    <= in_q.req_type ? cur_col : col_next;
      res.printed       <= !in_q.req_type && print;
      res.printed_total <= in_q.req_type ? count : count_inc;
    end else if (cmd.read_capture) begin
      res.cell_char <= read_ok ? rd_data[7:0] : 8'h00;
      res.cell_attr <= read_ok ? rd_data[15:8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  assign stat.is_read   = in_q.req_type;
  assign stat.do_clear  = !in_q.req_type && clear;
  assign stat.do_scroll = !in_q.req_type && print && scroll;
  assign stat.fill_done = (fill_addr == fill_last);
  assign stat.out_free  = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROW_W'(SCREEN_HEIGHT)) && (cur_col < COL_W'(SCREEN_WIDTH)))
    else $error("cursor outside screen");
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top_row < ROW_W'(SCREEN_HEIGHT))
    else $error("top row offset outside screen");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output word overwritten before taken");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> fill_addr <= fill_last)
    else $error("fill sweep ran past its last cell");
`endif

endmodule

FILE: rtl/core/text_console_cursor_engine_unit.sv
// Text console cursor engine top level: tcce_ctrl sequencer plus tcce_dpath; uses tcce_pkg.
// A result word is loaded from ST_OUT once the output is free; a read goes via ST_READ.
// A new word is taken only in ST_IDLE, once the last result is loaded; a scroll fills 80
// cells and a clear 2000, one cell write per cycle via the single cell store write port.
// Reset: synchronous; a sweep sets all 2000 cells to char 0, attr 0x0F, with in_ready low.
module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcce_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
